>>> rtl/core/zigzag_varint_delta_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the zigzag varint delta decoder
// Same-cycle and next-cycle implication checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_VARINT_DELTA_DECODER_UNIT_ASSERT_SVH
`define ZIGZAG_VARINT_DELTA_DECODER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ZVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ZVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/zvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zvd_pkg
// Shared types, constants and the CRC-32 byte update of the decoder.
// ----------------------------------------------------------------------------
package zvd_pkg;

    localparam int ZVD_ACC_W      = 33;
    localparam int ZVD_ACC_BYTES  = 5;
    localparam int ZVD_DIGIT_BITS = 7;
    localparam int ZVD_COUNT_W    = 24;
    localparam int ZVD_VALUE_W    = 32;
    localparam int ZVD_CFG_IDX_W  = 2;
    localparam int ZVD_Q_DEPTH    = 2;

    localparam logic [31:0] ZVD_CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ZVD_CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [ZVD_CFG_IDX_W-1:0] {
        CFG_ITEM_WIDTH_MODE = 2'd0,
        CFG_ITEM_COUNT      = 2'd1,
        CFG_EXPECTED_CRC    = 2'd2
    } t_zvd_cfg_idx;

    typedef struct packed {
        logic [ZVD_VALUE_W-1:0] delta;
        logic                   last;
    } t_zvd_entry;

    function automatic logic [31:0] zvd_crc_byte(input logic [31:0] crc,
                                                 input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ ZVD_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/zvd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zvd_front
// Takes stream bytes, assembles LEB128 varints and pushes zigzag deltas.
// ----------------------------------------------------------------------------
module zvd_front #(
    parameter int MAX_VARINT_BYTES = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [zvd_pkg::ZVD_COUNT_W-1:0] i_item_count,
    input  logic                            i_valid,
    input  logic [7:0]                      i_in_byte,
    output logic                            o_stall,
    input  logic                            i_q_full,
    output logic                            o_push,
    output zvd_pkg::t_zvd_entry             o_entry
);
    import zvd_pkg::*;

    localparam int CW = $clog2(MAX_VARINT_BYTES + 1);

    logic [ZVD_ACC_W-1:0]   r_acc, n_acc, acc_upd;
    logic [CW-1:0]          r_bcnt, n_bcnt, bcnt_inc;
    logic [ZVD_COUNT_W-1:0] r_items, n_items;
    logic [5:0]             shamt;
    logic                   accept;
    logic                   active;
    logic                   finish;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign active  = r_items < i_item_count;

    always_comb begin
        shamt    = 6'(r_bcnt) * 6'(ZVD_DIGIT_BITS);
        acc_upd  = r_acc;
        if (r_bcnt < CW'(ZVD_ACC_BYTES)) begin
            acc_upd = r_acc | (ZVD_ACC_W'(i_in_byte[6:0]) << shamt);
        end
        bcnt_inc = r_bcnt + 1'b1;
        finish   = !i_in_byte[7] || (bcnt_inc >= CW'(MAX_VARINT_BYTES));

        n_acc    = r_acc;
        n_bcnt   = r_bcnt;
        n_items  = r_items;
        o_push   = 1'b0;
        o_entry.delta = acc_upd[ZVD_ACC_W-1:1] ^ {ZVD_VALUE_W{acc_upd[0]}};
        o_entry.last  = (r_items + 1'b1) == i_item_count;

        if (accept && active) begin
            if (finish) begin
                n_acc   = '0;
                n_bcnt  = '0;
                n_items = r_items + 1'b1;
                o_push  = 1'b1;
            end else begin
                n_acc  = acc_upd;
                n_bcnt = bcnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_bcnt  <= '0;
            r_items <= '0;
        end else begin
            r_acc   <= n_acc;
            r_bcnt  <= n_bcnt;
            r_items <= n_items;
        end
    end

endmodule

>>> rtl/core/zvd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zvd_queue
// Short FIFO of decoded deltas between the front and back ends.
// ----------------------------------------------------------------------------
module zvd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  zvd_pkg::t_zvd_entry i_wdata,
    output logic                o_full,
    output logic                o_valid,
    output zvd_pkg::t_zvd_entry o_rdata,
    input  logic                i_pop
);
    import zvd_pkg::*;
    `include "zigzag_varint_delta_decoder_unit_assert.svh"

    localparam int PW = (ZVD_Q_DEPTH > 1) ? $clog2(ZVD_Q_DEPTH) : 1;
    localparam int NW = $clog2(ZVD_Q_DEPTH + 1);

    t_zvd_entry    r_mem [ZVD_Q_DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [NW-1:0] r_count, n_count;

    assign o_full  = r_count == NW'(ZVD_Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(ZVD_Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(ZVD_Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `ZVD_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ZVD_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `ZVD_ASSERT_NXT(a_q_fill, i_clk, i_rst_n, i_push && !i_pop, o_valid, "pushed entry lost")

endmodule

>>> rtl/core/zvd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zvd_back
// Accumulates deltas, updates the CRC-32 and holds the result register.
// ----------------------------------------------------------------------------
module zvd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_mode,
    input  logic [31:0]                     i_expected_crc,
    input  logic                            i_q_valid,
    input  zvd_pkg::t_zvd_entry             i_q_data,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [zvd_pkg::ZVD_VALUE_W-1:0] o_item_value,
    output logic                            o_is_last,
    output logic                            o_crc_match
);
    import zvd_pkg::*;
    `include "zigzag_varint_delta_decoder_unit_assert.svh"

    logic [ZVD_VALUE_W-1:0] r_sum, n_sum, sum;
    logic [31:0]            r_crc, n_crc, crc_lo, crc_hi;
    logic [ZVD_VALUE_W-1:0] r_value, n_value, val;
    logic                   r_valid, n_valid;
    logic                   r_last, n_last;
    logic                   r_match, n_match;

    assign o_q_pop = i_q_valid && (!r_valid || !i_stall);

    always_comb begin
        sum    = r_sum + i_q_data.delta;
        val    = i_mode ? sum : {16'h0, sum[15:0]};
        crc_lo = zvd_crc_byte(zvd_crc_byte(r_crc, val[7:0]), val[15:8]);
        crc_hi = zvd_crc_byte(zvd_crc_byte(crc_lo, val[23:16]), val[31:24]);

        n_sum   = r_sum;
        n_crc   = r_crc;
        n_value = r_value;
        n_last  = r_last;
        n_match = r_match;
        n_valid = r_valid && i_stall;
        if (o_q_pop) begin
            n_sum   = sum;
            n_crc   = i_mode ? crc_hi : crc_lo;
            n_value = val;
            n_last  = i_q_data.last;
            n_match = i_q_data.last && (~n_crc == i_expected_crc);
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_crc   <= ZVD_CRC_INIT;
            r_valid <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_crc   <= n_crc;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_last  <= n_last;
        r_match <= n_match;
    end

    assign o_valid      = r_valid;
    assign o_item_value = r_value;
    assign o_is_last    = r_last;
    assign o_crc_match  = r_match;

    `ZVD_ASSERT_IMP(a_match_with_last, i_clk, i_rst_n,
                    o_valid && o_crc_match, o_is_last, "crc match without last")
    `ZVD_ASSERT_IMP(a_narrow_upper, i_clk, i_rst_n,
                    o_valid && !i_mode, o_item_value[31:16] == 16'h0,
                    "upper bits set in 16-bit mode")
    `ZVD_ASSERT_NXT(a_pop_loads, i_clk, i_rst_n, o_q_pop, o_valid, "popped item not presented")

endmodule

>>> rtl/core/zigzag_varint_delta_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_varint_delta_decoder_unit
// Zigzag LEB128 delta decoder with CRC-32 check over the emitted items.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while input stall is low. The front end
// builds each varint and pushes the zigzag delta into a two-entry queue;
// the back end adds it to the running sum and folds 2 or 4 item bytes into
// the CRC in the same cycle. An item is registered in the queue and then in
// the result register; items keep up with one per cycle while output stall
// is low. Input stall rises only when the queue is full because the result
// register is held by output stall. Bytes after item_count items are
// accepted and dropped; a new run starts from reset.
module zigzag_varint_delta_decoder_unit #(
    parameter int MAX_VARINT_BYTES = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [zvd_pkg::ZVD_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_in_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [zvd_pkg::ZVD_VALUE_W-1:0]   o_item_value,
    output logic                              o_is_last,
    output logic                              o_crc_match
);
    import zvd_pkg::*;

    logic                   r_mode;
    logic [ZVD_COUNT_W-1:0] r_item_count;
    logic [31:0]            r_expected_crc;

    logic       q_full;
    logic       q_valid;
    logic       q_push;
    logic       q_pop;
    t_zvd_entry q_wdata;
    t_zvd_entry q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_item_count   <= '0;
            r_expected_crc <= '0;
        end else if (i_cfg_we) begin
            case (t_zvd_cfg_idx'(i_cfg_idx))
                CFG_ITEM_WIDTH_MODE: r_mode         <= i_cfg_data[0];
                CFG_ITEM_COUNT:      r_item_count   <= i_cfg_data[ZVD_COUNT_W-1:0];
                CFG_EXPECTED_CRC:    r_expected_crc <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    zvd_front #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_count (r_item_count),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .o_stall      (o_stall),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_entry      (q_wdata)
    );

    zvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_rdata),
        .i_pop   (q_pop)
    );

    zvd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_mode),
        .i_expected_crc (r_expected_crc),
        .i_q_valid      (q_valid),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_item_value   (o_item_value),
        .o_is_last      (o_is_last),
        .o_crc_match    (o_crc_match)
    );

endmodule
